FILE: hdl/bsa_pkg.sv
package bsa_pkg;

	localparam int MAPS_PER_POOL_DEF = 8;
	localparam int BITS_PER_MAP_DEF  = 8192;
	localparam int WORD_BITS_DEF     = 32;

	localparam int ENTRY_W   = 16;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_DATA_MAPS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INODE_MAPS = 1'd1;
	localparam logic [CFG_W-1:0]     MAPS_RESET     = 4'd8;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SET,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr_wr;
		logic scan_run;
		logic set_wr;
		logic free_rd;
		logic free_wr;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_hit;
		logic scan_empty;
		logic out_free;
	} sts_t;

endpackage

FILE: hdl/bsa_ctrl.sv
module bsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          kind,
	input  bsa_pkg::sts_t sts,
	output bsa_pkg::cmd_t cmd,
	output logic          in_stall
);
	import bsa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = (kind == KIND_FREE) ? ST_FREE_RD : ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_hit) state_d = ST_SET;
				else if (sts.scan_empty) state_d = ST_DONE;
			end
			ST_SET:     state_d = ST_DONE;
			ST_FREE_RD: state_d = ST_FREE_WR;
			ST_FREE_WR: state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR:   cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_SCAN:    cmd.scan_run = 1'b1;
			ST_SET:     cmd.set_wr = 1'b1;
			ST_FREE_RD: cmd.free_rd = 1'b1;
			ST_FREE_WR: cmd.free_wr = 1'b1;
			ST_DONE:    cmd.load_out = sts.out_free;
			default:    cmd = '0;
		endcase
	end

endmodule

FILE: hdl/bsa_dpath.sv
module bsa_dpath #(
	parameter int MAPS_PER_POOL = bsa_pkg::MAPS_PER_POOL_DEF,
	parameter int BITS_PER_MAP  = bsa_pkg::BITS_PER_MAP_DEF,
	parameter int WORD_BITS     = bsa_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bsa_pkg::cmd_t                 cmd,
	output bsa_pkg::sts_t                 sts,
	input  logic                          pool,
	input  logic [bsa_pkg::ENTRY_W-1:0]   entry_number,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [bsa_pkg::ENTRY_W-1:0]   granted_number,
	output logic                          status,
	input  logic                          cfg_we,
	input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsa_pkg::CFG_W-1:0]     cfg_wdata
);
	import bsa_pkg::*;

	localparam int WB_LOG  = $clog2(WORD_BITS);
	localparam int BM_LOG  = $clog2(BITS_PER_MAP);
	localparam int WPM     = BITS_PER_MAP / WORD_BITS;
	localparam int WPM_LOG = BM_LOG - WB_LOG;
	localparam int WPP     = MAPS_PER_POOL * WPM;
	localparam int TOTAL   = 2 * WPP;
	localparam int AW      = $clog2(TOTAL);
	localparam int SW      = $clog2(WPP + 1);

	logic [WORD_BITS-1:0] mem [TOTAL];
	logic [WORD_BITS-1:0] rd_data_q;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 wr_en;

	logic [CFG_W-1:0] data_maps_q;
	logic [CFG_W-1:0] inode_maps_q;
	logic [AW-1:0]    clr_q;

	logic             pool_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [SW-1:0]    limit_q;
	logic [SW-1:0]    sidx_q;
	logic [SW-1:0]    sidx_s1;
	logic             pend_s1;

	logic [AW-1:0]        set_addr_q;
	logic [WORD_BITS-1:0] set_word_q;
	logic [ENTRY_W-1:0]   res_num_q;
	logic                 res_full_q;

	logic                 out_valid_q;
	logic [ENTRY_W-1:0]   granted_q;
	logic                 status_q;

	logic [CFG_W-1:0]     maps_sel;
	logic [4:0]           maps_n;
	logic [31:0]          limit32;
	logic [31:0]          scan_a32;
	logic [31:0]          hit_a32;
	logic [31:0]          free_a32;
	logic [31:0]          free_map32;
	logic                 free_in_range;
	logic [WORD_BITS-1:0] free_bit;
	logic [WORD_BITS-1:0] first_mask;
	logic [WORD_BITS-1:0] zeros;
	logic [WORD_BITS-1:0] low_zero;
	logic [WB_LOG-1:0]    bitpos;
	logic [31:0]          num32;
	logic                 hit;
	logic                 empty;

	always_comb begin
		maps_sel = pool ? inode_maps_q : data_maps_q;
		maps_n   = (5'(maps_sel) > 5'(MAPS_PER_POOL)) ? 5'(MAPS_PER_POOL) : 5'(maps_sel);
		limit32  = 32'(maps_n) << WPM_LOG;
	end

	always_comb begin
		scan_a32      = 32'(sidx_q) + (pool_q ? 32'(WPP) : 32'd0);
		hit_a32       = 32'(sidx_s1) + (pool_q ? 32'(WPP) : 32'd0);
		free_map32    = 32'(entry_q) >> BM_LOG;
		free_in_range = free_map32 < 32'(MAPS_PER_POOL);
		free_a32      = (32'(entry_q) >> WB_LOG) + (pool_q ? 32'(WPP) : 32'd0);
		free_bit      = WORD_BITS'(1) << entry_q[WB_LOG-1:0];
	end

	always_comb begin
		first_mask    = '0;
		first_mask[0] = (sidx_s1[WPM_LOG-1:0] == '0);
		zeros         = ~(rd_data_q | first_mask);
		low_zero      = zeros & (~zeros + WORD_BITS'(1));
		bitpos        = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (low_zero[i]) bitpos = bitpos | WB_LOG'(i);
		end
		num32 = (32'(sidx_s1) << WB_LOG) | 32'(bitpos);
		hit   = pend_s1 && (zeros != '0);
		empty = !pend_s1 && (sidx_q >= limit_q);
	end

	always_comb begin
		rd_addr = cmd.free_rd ? free_a32[AW-1:0] : scan_a32[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (cmd.clr_wr) begin
			wr_en = 1'b1;
		end else if (cmd.set_wr) begin
			wr_en   = 1'b1;
			wr_addr = set_addr_q;
			wr_data = set_word_q;
		end else if (cmd.free_wr && free_in_range) begin
			wr_en   = 1'b1;
			wr_addr = free_a32[AW-1:0];
			wr_data = rd_data_q & ~free_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_maps_q  <= MAPS_RESET;
			inode_maps_q <= MAPS_RESET;
			clr_q        <= '0;
			pend_s1      <= 1'b0;
			sidx_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DATA_MAPS:  data_maps_q <= cfg_wdata;
					REG_INODE_MAPS: inode_maps_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.clr_wr) clr_q <= clr_q + AW'(1);
			if (cmd.accept) begin
				sidx_q  <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.scan_run) begin
				pend_s1 <= (sidx_q < limit_q) && !hit;
				if (sidx_q < limit_q) sidx_q <= sidx_q + SW'(1);
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pool_q  <= pool;
			entry_q <= entry_number;
			limit_q <= limit32[SW-1:0];
		end
		if (cmd.scan_run) sidx_s1 <= sidx_q;
		if (cmd.scan_run && hit) begin
			set_addr_q <= hit_a32[AW-1:0];
			set_word_q <= rd_data_q | low_zero;
			res_num_q  <= num32[ENTRY_W-1:0];
			res_full_q <= STATUS_DONE;
		end else if (cmd.scan_run && empty) begin
			res_num_q  <= '0;
			res_full_q <= STATUS_FULL;
		end else if (cmd.free_wr) begin
			res_num_q  <= entry_q;
			res_full_q <= STATUS_DONE;
		end
		if (cmd.load_out) begin
			granted_q <= res_num_q;
			status_q  <= res_full_q;
		end
	end

	always_comb begin
		sts.clr_last   = (clr_q == AW'(TOTAL - 1));
		sts.scan_hit   = hit;
		sts.scan_empty = empty;
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid      = out_valid_q;
	assign granted_number = granted_q;
	assign status         = status_q;

endmodule

FILE: hdl/bitmap_slot_allocator.sv
// channel | signals                                   | moves
// in      | in_valid, in_stall, kind, pool,            | one request beat
//         | entry_number                              |
// out     | out_valid, out_stall, granted_number,      | one result beat
//         | status                                    |
// cfg     | cfg_we, cfg_index, cfg_wdata              | one register write
//
// Free: the word is read (ST_FREE_RD), then modified and written back
// (ST_FREE_WR) before the result is ready. Allocate: the scan reads bitmap
// words in order until the first one with a clear bit (bit 0 of each map
// counts as set); the word memory is read once a cycle, so a full pool of
// 2048 words is read to its end. After reset a clearing pass zeroes all
// 2 * MAPS_PER_POOL * BITS_PER_MAP / WORD_BITS words of the memory (4096 by
// default), one word a cycle; in_stall is high throughout.
// A result held by out_stall waits in the output register; the next request is
// still taken and finishes up to its result, then waits for the register.
module bitmap_slot_allocator #(
	parameter int MAPS_PER_POOL = bsa_pkg::MAPS_PER_POOL_DEF,
	parameter int BITS_PER_MAP  = bsa_pkg::BITS_PER_MAP_DEF,
	parameter int WORD_BITS     = bsa_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic                          pool,
	input  logic [bsa_pkg::ENTRY_W-1:0]   entry_number,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bsa_pkg::ENTRY_W-1:0]   granted_number,
	output logic                          status,
	input  logic                          cfg_we,
	input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsa_pkg::CFG_W-1:0]     cfg_wdata
);
	import bsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	bsa_dpath #(
		.MAPS_PER_POOL (MAPS_PER_POOL),
		.BITS_PER_MAP  (BITS_PER_MAP),
		.WORD_BITS     (WORD_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.pool           (pool),
		.entry_number   (entry_number),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.granted_number (granted_number),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata)
	);

endmodule

FILE: hdl/bsa_checker.sv
module bsa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          kind,
	input logic                          pool,
	input logic [bsa_pkg::ENTRY_W-1:0]   entry_number,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [bsa_pkg::ENTRY_W-1:0]   granted_number,
	input logic                          status,
	input logic                          cfg_we,
	input logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bsa_pkg::CFG_W-1:0]     cfg_wdata
);
	import bsa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted_number) && $stable(status))
		else $error("result beat changed while stalled");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_FULL) |-> granted_number == '0)
		else $error("full result carries a nonzero number");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted on two consecutive cycles");

	a_full_not_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == KIND_FREE) |=> ##3 !(out_valid && $rose(out_valid)
		&& (status == STATUS_FULL)))
		else $error("free request reported full");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);

FILE: verif/tb_bitmap_slot_allocator.sv
`timescale 1ns / 100ps

module tb_bitmap_slot_allocator;
	import bsa_pkg::*;

	localparam int MAPS = MAPS_PER_POOL_DEF;
	localparam int BITS = BITS_PER_MAP_DEF;
	localparam int POOL_DATA = 0;
	localparam int POOL_INODE = 1;

	typedef struct {
		logic               kind;
		logic               pool;
		logic [ENTRY_W-1:0] entry;
	} alloc_req_t;

	typedef struct {
		logic [ENTRY_W-1:0] number;
		logic               status;
	} grant_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 kind = KIND_ALLOC;
	logic                 pool = 1'b0;
	logic [ENTRY_W-1:0]   entry_number = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ENTRY_W-1:0]   granted_number;
	logic                 status;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DATA_MAPS;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	alloc_req_t pending_reqs[$];
	grant_t     expected_grants[$];
	int         reqs_outstanding = 0;
	bit         req_taken = 1'b0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         mismatch_count = 0;

	bit [BITS-1:0]  map_bits [2][MAPS];
	logic [CFG_W-1:0] data_maps_cfg = MAPS_RESET;
	logic [CFG_W-1:0] inode_maps_cfg = MAPS_RESET;

	bitmap_slot_allocator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.pool           (pool),
		.entry_number   (entry_number),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted_number (granted_number),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic grant_t predict_grant(alloc_req_t r);
		grant_t g;
		int unsigned n;
		g.number = r.entry;
		g.status = STATUS_DONE;
		if (r.kind == KIND_FREE) begin
			if (r.entry / BITS < MAPS)
				map_bits[r.pool][r.entry / BITS][r.entry % BITS] = 1'b0;
			return g;
		end
		n = 32'((r.pool == POOL_INODE[0]) ? inode_maps_cfg : data_maps_cfg);
		if (n > MAPS)
			n = MAPS;
		for (int unsigned m = 0; m < n; m++) begin
			for (int unsigned b = 1; b < BITS; b++) begin
				if (!map_bits[r.pool][m][b]) begin
					map_bits[r.pool][m][b] = 1'b1;
					g.number = ENTRY_W'(m * BITS + b);
					return g;
				end
			end
		end
		g.number = '0;
		g.status = STATUS_FULL;
		return g;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic queue_req(logic k, logic p, logic [ENTRY_W-1:0] e);
		alloc_req_t r;
		r.kind = k;
		r.pool = p;
		r.entry = e;
		pending_reqs.push_back(r);
		reqs_outstanding++;
	endtask

	task automatic queue_random_req();
		int sel;
		logic [ENTRY_W-1:0] e;
		sel = $urandom_range(99);
		if (sel < 50) begin
			queue_req(KIND_ALLOC, 1'($urandom_range(1)), ENTRY_W'($urandom));
		end else if (sel < 85) begin
			e = ENTRY_W'($urandom_range(255));
			if ($urandom_range(3) == 0)
				e[ENTRY_W-1:ENTRY_W-3] = 3'($urandom_range(7));
			queue_req(KIND_FREE, 1'($urandom_range(1)), e);
		end else begin
			queue_req(KIND_FREE, 1'($urandom_range(1)), ENTRY_W'($urandom));
		end
	endtask

	task automatic wait_idle();
		while (reqs_outstanding != 0 || expected_grants.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int data_maps, int inode_maps, int send_idle, int recv_stall,
			int count);
		wait_idle();
		write_reg(REG_DATA_MAPS, CFG_W'(data_maps));
		write_reg(REG_INODE_MAPS, CFG_W'(inode_maps));
		send_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
		repeat (count)
			queue_random_req();
	endtask

	// driver: load the next beat once the current one is taken, and drive out_stall at random
	always @(negedge clk) begin
		alloc_req_t cur;
		if (!in_valid || req_taken) begin
			req_taken = 1'b0;
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur = pending_reqs.pop_front();
				in_valid <= 1'b1;
				kind <= cur.kind;
				pool <= cur.pool;
				entry_number <= cur.entry;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// monitor: track register writes, predict on accepted requests, check results
	always @(posedge clk) begin
		alloc_req_t beat;
		grant_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DATA_MAPS:  data_maps_cfg = cfg_wdata;
					REG_INODE_MAPS: inode_maps_cfg = cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_grants.size() == 0) begin
					report_mismatch($sformatf("result number=%0d status=%0d with none pending",
						granted_number, status));
				end else begin
					want = expected_grants.pop_front();
					if (granted_number !== want.number)
						report_mismatch($sformatf("granted_number %0d, want %0d",
							granted_number, want.number));
					if (status !== want.status)
						report_mismatch($sformatf("status %0b, want %0b (number %0d)",
							status, want.status, want.number));
				end
			end
			if (in_valid && !in_stall) begin
				beat.kind = kind;
				beat.pool = pool;
				beat.entry = entry_number;
				expected_grants.push_back(predict_grant(beat));
				reqs_outstanding--;
				req_taken = 1'b1;
			end
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		queue_req(KIND_ALLOC, POOL_DATA[0], 16'hFFFF);
		queue_req(KIND_ALLOC, POOL_DATA[0], 16'h0000);
		queue_req(KIND_ALLOC, POOL_DATA[0], 16'h1234);
		queue_req(KIND_ALLOC, POOL_INODE[0], 16'h0000);
		queue_req(KIND_ALLOC, POOL_INODE[0], 16'hFFFF);
		queue_req(KIND_FREE, POOL_DATA[0], 16'd2);
		queue_req(KIND_ALLOC, POOL_DATA[0], 16'd0);
		queue_req(KIND_FREE, POOL_DATA[0], 16'd0);
		queue_req(KIND_ALLOC, POOL_DATA[0], 16'd0);
		queue_req(KIND_FREE, POOL_DATA[0], 16'hFFFF);
		queue_req(KIND_FREE, POOL_INODE[0], 16'hFFFF);
		queue_req(KIND_FREE, POOL_DATA[0], 16'd8192);
		queue_req(KIND_FREE, POOL_DATA[0], 16'd100);
		queue_req(KIND_FREE, POOL_INODE[0], 16'd1);
		queue_req(KIND_ALLOC, POOL_INODE[0], 16'd0);
		queue_req(KIND_ALLOC, POOL_INODE[0], 16'd0);
		queue_req(KIND_FREE, POOL_DATA[0], 16'h5555);
		queue_req(KIND_FREE, POOL_INODE[0], 16'hAAAA);
		queue_req(KIND_ALLOC, POOL_DATA[0], 16'h5555);
		wait_idle();
		write_reg(REG_DATA_MAPS, CFG_W'(0));
		queue_req(KIND_ALLOC, POOL_DATA[0], 16'd0);
		queue_req(KIND_ALLOC, POOL_INODE[0], 16'd0);
		wait_idle();
		write_reg(REG_DATA_MAPS, CFG_W'(9));
		write_reg(REG_INODE_MAPS, CFG_W'(15));
		queue_req(KIND_ALLOC, POOL_DATA[0], 16'd0);
		queue_req(KIND_ALLOC, POOL_INODE[0], 16'd0);

		run_phase(1, 8, 0, 0, 100);
		run_phase(15, 0, 87, 0, 100);
		run_phase(0, 1, 0, 87, 100);
		run_phase(8, 15, 33, 33, 100);
		run_phase(3, 5, 0, 0, 100);
		wait_idle();
		repeat (40) @(negedge clk);

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
hdl/bsa_pkg.sv
hdl/bsa_ctrl.sv
hdl/bsa_dpath.sv
hdl/bitmap_slot_allocator.sv
hdl/bsa_checker.sv
verif/tb_bitmap_slot_allocator.sv
